/* design/srcu_pkg.sv */
// Shared types, register indexes and fixed-point helpers for the sensor
// reading compensation unit. No dependencies.
`default_nettype none
package srcu_pkg;

  localparam int unsigned IdxWidth  = 3;
  localparam int unsigned DivStages = 32;

  localparam logic [IdxWidth-1:0] CFG_CAL_TEMP    = 3'd0;
  localparam logic [IdxWidth-1:0] CFG_CAL_PRESS_A = 3'd1;
  localparam logic [IdxWidth-1:0] CFG_CAL_PRESS_B = 3'd2;
  localparam logic [IdxWidth-1:0] CFG_CAL_PRESS_C = 3'd3;
  localparam logic [IdxWidth-1:0] CFG_CAL_HUM_A   = 3'd4;
  localparam logic [IdxWidth-1:0] CFG_CAL_HUM_B   = 3'd5;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        big;
    logic        zero;
    logic [31:0] centi;
    logic [31:0] fine;
    logic [16:0] hum;
  } div_beat_t;

  typedef struct packed {
    logic [31:0] quo;
    logic        big;
    logic        zero;
    logic [31:0] centi;
    logic [31:0] fine;
    logic [16:0] hum;
  } div_res_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

/* design/srcu_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on srcu_pkg.
`default_nettype none
module srcu_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire srcu_pkg::div_beat_t in_beat,
  output logic                    out_vld,
  output srcu_pkg::div_res_t      out_res
);

  localparam int unsigned N = srcu_pkg::DivStages;

  logic [N-1:0]   vld;
  logic [31:0]    rem [N];
  logic [31:0]    num [N];
  logic [31:0]    quo [N];
  srcu_pkg::div_beat_t side [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [31:0] rem_in, num_in, quo_in;
    srcu_pkg::div_beat_t side_in;
    logic [32:0] trial, diff;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = in_beat.num;
      assign quo_in  = '0;
      assign side_in = in_beat;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign num_in  = num[k-1];
      assign quo_in  = quo[k-1];
      assign side_in = side[k-1];
    end
    assign trial = {rem_in, num_in[31]};
    assign diff  = trial - {1'b0, side_in.den};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[32]) begin
          rem[k] <= diff[31:0];
          quo[k] <= {quo_in[30:0], 1'b1};
        end else begin
          rem[k] <= trial[31:0];
          quo[k] <= {quo_in[30:0], 1'b0};
        end
        num[k]  <= {num_in[30:0], 1'b0};
        side[k] <= side_in;
      end
    end
  end

  assign out_vld       = vld[N-1];
  assign out_res.quo   = quo[N-1];
  assign out_res.big   = side[N-1].big;
  assign out_res.zero  = side[N-1].zero;
  assign out_res.centi = side[N-1].centi;
  assign out_res.fine  = side[N-1].fine;
  assign out_res.hum   = side[N-1].hum;

endmodule
`default_nettype wire

/* design/sensor_reading_compensation_unit.sv */
// Pipeline of 16 formula stages, 32 divider stages and 3 pressure trim stages.
// Throughput one reading per cycle; the whole pipeline holds while a result
// waits under out_stall. Synchronous active-high rst clears valid bits and
// calibration words to zero. Depends on srcu_pkg and srcu_div.
`default_nettype none
module sensor_reading_compensation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [19:0] raw_temperature,
  input  wire logic [19:0] raw_pressure,
  input  wire logic [15:0] raw_humidity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      temperature_centi,
  output logic [31:0]      fine_temperature,
  output logic [31:0]      pressure_pa,
  output logic [16:0]      humidity_q10
);

  logic [47:0] cal_temp, cal_press_a, cal_press_b, cal_press_c, cal_hum_b;
  logic [23:0] cal_hum_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= '0;
      cal_press_a <= '0;
      cal_press_b <= '0;
      cal_press_c <= '0;
      cal_hum_a   <= '0;
      cal_hum_b   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srcu_pkg::CFG_CAL_TEMP:    cal_temp    <= cfg_data;
        srcu_pkg::CFG_CAL_PRESS_A: cal_press_a <= cfg_data;
        srcu_pkg::CFG_CAL_PRESS_B: cal_press_b <= cfg_data;
        srcu_pkg::CFG_CAL_PRESS_C: cal_press_c <= cfg_data;
        srcu_pkg::CFG_CAL_HUM_A:   cal_hum_a   <= cfg_data[23:0];
        srcu_pkg::CFG_CAL_HUM_B:   cal_hum_b   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'b0, cal_temp[15:0]};
  assign t2 = srcu_pkg::sx16(cal_temp[31:16]);
  assign t3 = srcu_pkg::sx16(cal_temp[47:32]);
  assign p1 = {16'b0, cal_press_a[15:0]};
  assign p2 = srcu_pkg::sx16(cal_press_a[31:16]);
  assign p3 = srcu_pkg::sx16(cal_press_a[47:32]);
  assign p4 = srcu_pkg::sx16(cal_press_b[15:0]);
  assign p5 = srcu_pkg::sx16(cal_press_b[31:16]);
  assign p6 = srcu_pkg::sx16(cal_press_b[47:32]);
  assign p7 = srcu_pkg::sx16(cal_press_c[15:0]);
  assign p8 = srcu_pkg::sx16(cal_press_c[31:16]);
  assign p9 = srcu_pkg::sx16(cal_press_c[47:32]);
  assign h1 = {24'b0, cal_hum_a[7:0]};
  assign h3 = {24'b0, cal_hum_a[15:8]};
  assign h6 = srcu_pkg::sx8(cal_hum_a[23:16]);
  assign h2 = srcu_pkg::sx16(cal_hum_b[15:0]);
  assign h4 = srcu_pkg::sx16(cal_hum_b[31:16]);
  assign h5 = srcu_pkg::sx16(cal_hum_b[47:32]);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [15:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[14:0], in_valid};
    end
  end

  logic [31:0] s1_ta, s1_d, s2_m1, s2_dd, s3_v1, s3_m2, s4_fine;
  logic [19:0] s1_rp, s2_rp, s3_rp, s4_rp, s5_rp, s6_rp, s7_rp, s8_rp;
  logic [15:0] s1_rh, s2_rh, s3_rh, s4_rh, s5_rh, s6_rh;
  logic [31:0] s5_cm, s5_fine, s5_a, s5_q, s5_x;
  logic [31:0] s6_centi, s6_fine, s6_qq, s6_ap5, s6_p2a, s6_h5x, s6_xh6, s6_xh3;
  logic [31:0] s7_centi, s7_fine, s7_b1, s7_c1, s7_ap5, s7_p2a, s7_left, s7_r1, s7_r2;
  logic [31:0] s8_centi, s8_fine, s8_b, s8_aa, s8_left, s8_r3;
  logic [31:0] s9_centi, s9_fine, s9_a2m, s9_pb, s9_left, s9_r4;
  logic [31:0] s10_centi, s10_fine, s10_den, s10_pm, s10_left, s10_r5;
  logic [31:0] s11_centi, s11_fine, s11_den, s11_num, s11_left, s11_right;
  logic        s11_big;
  logic [31:0] s12_centi, s12_fine, s12_den, s12_num, s12_hx;
  logic [31:0] s13_centi, s13_fine, s13_den, s13_num, s13_hx, s13_s;
  logic [31:0] s14_centi, s14_fine, s14_den, s14_num, s14_hx, s14_ss;
  logic [31:0] s15_centi, s15_fine, s15_den, s15_num, s15_hx, s15_hm;
  logic [31:0] s16_centi, s16_fine, s16_den, s16_num;
  logic        s12_big, s13_big, s14_big, s15_big, s16_big;
  logic [16:0] s16_hum;
  logic [31:0] hx_next;

  assign hx_next = s15_hx - srcu_pkg::asr32(s15_hm, 4);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ta <= {15'b0, raw_temperature[19:3]} - {t1[30:0], 1'b0};
      s1_d  <= {16'b0, raw_temperature[19:4]} - t1;
      s1_rp <= raw_pressure;
      s1_rh <= raw_humidity;

      s2_m1 <= s1_ta * t2;
      s2_dd <= s1_d * s1_d;
      s2_rp <= s1_rp;
      s2_rh <= s1_rh;

      s3_v1 <= srcu_pkg::asr32(s2_m1, 11);
      s3_m2 <= srcu_pkg::asr32(s2_dd, 12) * t3;
      s3_rp <= s2_rp;
      s3_rh <= s2_rh;

      s4_fine <= s3_v1 + srcu_pkg::asr32(s3_m2, 14);
      s4_rp   <= s3_rp;
      s4_rh   <= s3_rh;

      s5_cm   <= s4_fine * 32'd5;
      s5_fine <= s4_fine;
      s5_a    <= srcu_pkg::asr32(s4_fine, 1) - 32'd64000;
      s5_q    <= srcu_pkg::asr32(srcu_pkg::asr32(s4_fine, 1) - 32'd64000, 2);
      s5_x    <= s4_fine - 32'd76800;
      s5_rp   <= s4_rp;
      s5_rh   <= s4_rh;

      s6_centi <= srcu_pkg::asr32(s5_cm + 32'd128, 8);
      s6_fine  <= s5_fine;
      s6_qq    <= s5_q * s5_q;
      s6_ap5   <= s5_a * p5;
      s6_p2a   <= p2 * s5_a;
      s6_h5x   <= h5 * s5_x;
      s6_xh6   <= s5_x * h6;
      s6_xh3   <= s5_x * h3;
      s6_rp    <= s5_rp;
      s6_rh    <= s5_rh;

      s7_centi <= s6_centi;
      s7_fine  <= s6_fine;
      s7_b1    <= srcu_pkg::asr32(s6_qq, 11) * p6;
      s7_c1    <= p3 * srcu_pkg::asr32(s6_qq, 13);
      s7_ap5   <= s6_ap5;
      s7_p2a   <= s6_p2a;
      s7_left  <= srcu_pkg::asr32({2'b0, s6_rh, 14'b0} - {h4[11:0], 20'b0}
                                  - s6_h5x + 32'd16384, 15);
      s7_r1    <= srcu_pkg::asr32(s6_xh6, 10);
      s7_r2    <= srcu_pkg::asr32(s6_xh3, 11) + 32'd32768;
      s7_rp    <= s6_rp;

      s8_centi <= s7_centi;
      s8_fine  <= s7_fine;
      s8_b     <= srcu_pkg::asr32(s7_b1 + {s7_ap5[30:0], 1'b0}, 2) + {p4[15:0], 16'b0};
      s8_aa    <= srcu_pkg::asr32(srcu_pkg::asr32(s7_c1, 3)
                                  + srcu_pkg::asr32(s7_p2a, 1), 18);
      s8_left  <= s7_left;
      s8_r3    <= s7_r1 * s7_r2;
      s8_rp    <= s7_rp;

      s9_centi <= s8_centi;
      s9_fine  <= s8_fine;
      s9_a2m   <= (32'd32768 + s8_aa) * p1;
      s9_pb    <= (32'd1048576 - {12'b0, s8_rp}) - srcu_pkg::asr32(s8_b, 12);
      s9_left  <= s8_left;
      s9_r4    <= srcu_pkg::asr32(s8_r3, 10) + 32'd2097152;

      s10_centi <= s9_centi;
      s10_fine  <= s9_fine;
      s10_den   <= srcu_pkg::asr32(s9_a2m, 15);
      s10_pm    <= s9_pb * 32'd3125;
      s10_left  <= s9_left;
      s10_r5    <= s9_r4 * h2;

      s11_centi <= s10_centi;
      s11_fine  <= s10_fine;
      s11_den   <= s10_den;
      s11_big   <= s10_pm[31];
      s11_num   <= s10_pm[31] ? s10_pm : {s10_pm[30:0], 1'b0};
      s11_left  <= s10_left;
      s11_right <= srcu_pkg::asr32(s10_r5 + 32'd8192, 14);

      s12_centi <= s11_centi;
      s12_fine  <= s11_fine;
      s12_den   <= s11_den;
      s12_num   <= s11_num;
      s12_big   <= s11_big;
      s12_hx    <= s11_left * s11_right;

      s13_centi <= s12_centi;
      s13_fine  <= s12_fine;
      s13_den   <= s12_den;
      s13_num   <= s12_num;
      s13_big   <= s12_big;
      s13_hx    <= s12_hx;
      s13_s     <= srcu_pkg::asr32(s12_hx, 15);

      s14_centi <= s13_centi;
      s14_fine  <= s13_fine;
      s14_den   <= s13_den;
      s14_num   <= s13_num;
      s14_big   <= s13_big;
      s14_hx    <= s13_hx;
      s14_ss    <= s13_s * s13_s;

      s15_centi <= s14_centi;
      s15_fine  <= s14_fine;
      s15_den   <= s14_den;
      s15_num   <= s14_num;
      s15_big   <= s14_big;
      s15_hx    <= s14_hx;
      s15_hm    <= srcu_pkg::asr32(s14_ss, 7) * h1;

      s16_centi <= s15_centi;
      s16_fine  <= s15_fine;
      s16_den   <= s15_den;
      s16_num   <= s15_num;
      s16_big   <= s15_big;
      priority if (hx_next[31]) begin
        s16_hum <= '0;
      end else if (hx_next > 32'd419430400) begin
        s16_hum <= 17'(32'd419430400 >> 12);
      end else begin
        s16_hum <= hx_next[28:12];
      end
    end
  end

  srcu_pkg::div_beat_t div_in;
  srcu_pkg::div_res_t  div_out;
  logic                div_vld;

  assign div_in.num   = s16_num;
  assign div_in.den   = s16_den;
  assign div_in.big   = s16_big;
  assign div_in.zero  = (s16_den == '0);
  assign div_in.centi = s16_centi;
  assign div_in.fine  = s16_fine;
  assign div_in.hum   = s16_hum;

  srcu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (vld[15]),
    .in_beat (div_in),
    .out_vld (div_vld),
    .out_res (div_out)
  );

  logic [2:0]  pvld;
  logic [31:0] p0;
  logic [31:0] q1_p, q1_pa, q1_pb, q1_centi, q1_fine;
  logic [31:0] q2_p, q2_a, q2_b, q2_centi, q2_fine;
  logic [16:0] q1_hum, q2_hum;
  logic        q1_zero, q2_zero;
  logic [31:0] p0_s3;

  assign p0    = div_out.big ? {div_out.quo[30:0], 1'b0} : div_out.quo;
  assign p0_s3 = p0 >> 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= '0;
    end else if (en) begin
      pvld <= {pvld[1:0], div_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_p     <= p0;
      q1_pa    <= p0_s3 * p0_s3;
      q1_pb    <= (p0 >> 2) * p8;
      q1_zero  <= div_out.zero;
      q1_centi <= div_out.centi;
      q1_fine  <= div_out.fine;
      q1_hum   <= div_out.hum;

      q2_p     <= q1_p;
      q2_a     <= p9 * (q1_pa >> 13);
      q2_b     <= srcu_pkg::asr32(q1_pb, 13);
      q2_zero  <= q1_zero;
      q2_centi <= q1_centi;
      q2_fine  <= q1_fine;
      q2_hum   <= q1_hum;

      pressure_pa       <= q2_zero ? '0 :
                           q2_p + srcu_pkg::asr32(srcu_pkg::asr32(q2_a, 12) + q2_b + p7, 4);
      temperature_centi <= q2_centi;
      fine_temperature  <= q2_fine;
      humidity_q10      <= q2_hum;
    end
  end

  assign out_valid = pvld[2];

  a_stall_rule: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pressure_pa) && $stable(humidity_q10))
    else $error("stalled result changed");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_q10 <= 17'd102400)
    else $error("humidity above clamp");

  a_div_feed: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld) && $stable(pvld))
    else $error("pipeline moved while held");

endmodule
`default_nettype wire

/* tb/srcu_checker.sv */
// Checker for the sensor reading compensation unit: snoops the calibration port
// and both channels, predicts each compensated reading and compares it.
// Depends on srcu_pkg for the register indexes.
module srcu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  input  logic [15:0] raw_humidity,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] temperature_centi,
  input  logic [31:0] fine_temperature,
  input  logic [31:0] pressure_pa,
  input  logic [16:0] humidity_q10,
  output int          failures,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] centi;
    logic [31:0] fine;
    logic [31:0] press;
    logic [16:0] hum;
  } reading_t;

  logic [47:0] k_temp, k_pa, k_pb, k_pc, k_hb;
  logic [23:0] k_ha;
  reading_t    expected_readings[$];

  function automatic logic [31:0] sra(input logic [31:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                          input logic [15:0] rh);
    reading_t    r;
    logic [31:0] t1, t2, t3, v1, v2, d, fine;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, q, p;
    logic [31:0] h1, h2, h3, h4, h5, h6, x, lft, rgt, s;
    t1 = {16'd0, k_temp[15:0]};
    t2 = ext16(k_temp[31:16]);
    t3 = ext16(k_temp[47:32]);
    v1 = sra((sra({12'd0, rt}, 3) - (t1 << 1)) * t2, 11);
    d = sra({12'd0, rt}, 4) - t1;
    v2 = sra(sra(d * d, 12) * t3, 14);
    fine = v1 + v2;
    r.fine = fine;
    r.centi = sra(fine * 32'd5 + 32'd128, 8);

    p1 = {16'd0, k_pa[15:0]};
    p2 = ext16(k_pa[31:16]);
    p3 = ext16(k_pa[47:32]);
    p4 = ext16(k_pb[15:0]);
    p5 = ext16(k_pb[31:16]);
    p6 = ext16(k_pb[47:32]);
    p7 = ext16(k_pc[15:0]);
    p8 = ext16(k_pc[31:16]);
    p9 = ext16(k_pc[47:32]);
    a = sra(fine, 1) - 32'd64000;
    q = sra(a, 2);
    b = sra(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sra(b, 2) + (p4 << 16);
    a = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * a, 1), 18);
    a = sra((32'd32768 + a) * p1, 15);
    if (a == 32'd0) begin
      r.press = 32'd0;
    end else begin
      p = ((32'd1048576 - {12'd0, rp}) - sra(b, 12)) * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) * 32'd2;
      a = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
      b = sra((p >> 2) * p8, 13);
      r.press = p + sra(a + b + p7, 4);
    end

    h1 = {24'd0, k_ha[7:0]};
    h3 = {24'd0, k_ha[15:8]};
    h6 = {{24{k_ha[23]}}, k_ha[23:16]};
    h2 = ext16(k_hb[15:0]);
    h4 = ext16(k_hb[31:16]);
    h5 = ext16(k_hb[47:32]);
    x = fine - 32'd76800;
    lft = sra(({16'd0, rh} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    rgt = sra(sra(sra(x * h6, 10) * (sra(x * h3, 11) + 32'd32768), 10) + 32'd2097152, 0);
    rgt = sra(rgt * h2 + 32'd8192, 14);
    x = lft * rgt;
    s = sra(x, 15);
    x = x - sra(sra(s * s, 7) * h1, 4);
    if (x[31]) x = 32'd0;
    if (x > 32'd419430400) x = 32'd419430400;
    r.hum = 17'(x >> 12);
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    failures++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  assign pending = expected_readings.size();

  initial failures = 0;

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      {k_temp, k_pa, k_pb, k_pc, k_hb} = '0;
      k_ha = '0;
      expected_readings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report("unexpected beat", pressure_pa, 32'd0);
        end else begin
          want = expected_readings.pop_front();
          if (temperature_centi !== want.centi) report("temperature_centi", temperature_centi, want.centi);
          if (fine_temperature !== want.fine) report("fine_temperature", fine_temperature, want.fine);
          if (pressure_pa !== want.press) report("pressure_pa", pressure_pa, want.press);
          if (humidity_q10 !== want.hum) report("humidity_q10", {15'd0, humidity_q10}, {15'd0, want.hum});
        end
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(compensate(raw_temperature, raw_pressure, raw_humidity));
      if (cfg_we) begin
        case (cfg_index)
          srcu_pkg::CFG_CAL_TEMP:    k_temp = cfg_data;
          srcu_pkg::CFG_CAL_PRESS_A: k_pa = cfg_data;
          srcu_pkg::CFG_CAL_PRESS_B: k_pb = cfg_data;
          srcu_pkg::CFG_CAL_PRESS_C: k_pc = cfg_data;
          srcu_pkg::CFG_CAL_HUM_A:   k_ha = cfg_data[23:0];
          srcu_pkg::CFG_CAL_HUM_B:   k_hb = cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

/* tb/sensor_reading_compensation_unit_test.sv */
// Top of the compensation unit testbench: clock, reset, calibration phases,
// randomly paced readings and receiver stalls. Depends on srcu_pkg, the block
// and srcu_checker.
module sensor_reading_compensation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CalIdxUnused = 3'd6;
  localparam int         WatchdogLimit = 20000;
  localparam int         DrainCycles = 80;

  logic        clk, rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        in_valid, in_stall, out_valid, out_stall;
  logic [19:0] raw_temperature, raw_pressure;
  logic [15:0] raw_humidity;
  logic [31:0] temperature_centi, fine_temperature, pressure_pa;
  logic [16:0] humidity_q10;
  int          failures, pending;
  int          beats_sent;
  int          idle_cycles;
  bit          quiet;
  logic [47:0] cal_words[6];
  logic [2:0]  cal_idx[6] = '{srcu_pkg::CFG_CAL_TEMP, srcu_pkg::CFG_CAL_PRESS_A,
                              srcu_pkg::CFG_CAL_PRESS_B, srcu_pkg::CFG_CAL_PRESS_C,
                              srcu_pkg::CFG_CAL_HUM_A, srcu_pkg::CFG_CAL_HUM_B};

  sensor_reading_compensation_unit u_top (.*);
  srcu_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; raw_temperature = '0; raw_pressure = '0; raw_humidity = '0;
    out_stall = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("sensor_reading_compensation_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int r;
    bit held;
    held = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && beats_sent >= 400) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (quiet || r < 70) out_stall <= 1'b0;
      else if (r < 97) out_stall <= 1'b1;
      else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  task automatic send(input logic [19:0] rt, input logic [19:0] rp, input logic [15:0] rh);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = (quiet || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_temperature <= rt;
    raw_pressure <= rp;
    raw_humidity <= rh;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic program_cal(input bit stray);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cal_idx[i];
      cfg_data <= cal_words[i];
      @(posedge clk);
    end
    if (stray) begin
      cfg_index <= CalIdxUnused;
      cfg_data <= 48'({$urandom, $urandom});
      @(posedge clk);
      cfg_index <= CalIdxUnused + 3'd1;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic load_typical();
    cal_words[0] = {16'hFC18, 16'd26435, 16'd27504};
    cal_words[1] = {16'd3024, 16'hD643, 16'd36477};
    cal_words[2] = {16'hFFF9, 16'd140, 16'd2855};
    cal_words[3] = {16'd6000, 16'hC6F8, 16'd15500};
    cal_words[4] = {8'd30, 8'd0, 8'd75};
    cal_words[5] = {16'd50, 16'd313, 16'd362};
  endtask

  task automatic send_extremes();
    send('0, '0, '0);
    send('1, '1, '1);
    send('1, '0, '1);
    send('0, '1, '0);
    send(20'd519888, 20'd415148, 16'd30000);
    send(20'h80000, 20'h7FFFF, 16'h8000);
  endtask

  task automatic send_random(input int count, input bit near);
    for (int i = 0; i < count; i++) begin
      if (near && $urandom_range(0, 3) != 0)
        send(20'($urandom_range(400000, 600000)), 20'($urandom_range(250000, 500000)),
             16'($urandom_range(20000, 45000)));
      else
        send(20'($urandom), 20'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    beats_sent = 0;
    quiet = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_extremes();
    load_typical();
    program_cal(1'b1);
    send_extremes();
    send(20'd519888, 20'd415148, 16'd0);
    send(20'd519888, 20'd415148, 16'hFFFF);
    send_random(300, 1'b1);
    for (int i = 0; i < 6; i++) cal_words[i] = '1;
    program_cal(1'b0);
    send_extremes();
    send_random(150, 1'b0);
    for (int i = 0; i < 6; i++) cal_words[i] = '0;
    program_cal(1'b0);
    send_random(60, 1'b0);
    for (int ph = 0; ph < 9; ph++) begin
      quiet = (ph % 3 == 2);
      if (ph % 2 == 0) begin
        load_typical();
        for (int i = 0; i < 6; i++) cal_words[i] ^= 48'($urandom_range(0, 255));
      end else begin
        for (int i = 0; i < 6; i++) cal_words[i] = 48'({$urandom, $urandom});
      end
      program_cal(1'b0);
      send_random(150, ph % 2 == 0);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("sensor_reading_compensation_unit regression: pass");
    end else begin
      $display("sensor_reading_compensation_unit regression: fail");
    end
    $finish;
  end
endmodule
